/* rtl/core/bcfe_pkg.sv */
package bcfe_pkg;

    // key codes
    localparam logic [2:0] FUNC_NONE  = 3'd0;
    localparam logic [2:0] FUNC_LEFT  = 3'd1;
    localparam logic [2:0] FUNC_RIGHT = 3'd2;
    localparam logic [2:0] FUNC_INC   = 3'd3;
    localparam logic [2:0] FUNC_DEC   = 3'd4;

    // cursor positions around the ring
    localparam logic [3:0] POS_HOME    = 4'd0;
    localparam logic [3:0] POS_YEAR    = 4'd1;
    localparam logic [3:0] POS_MONTH   = 4'd2;
    localparam logic [3:0] POS_DATE    = 4'd3;
    localparam logic [3:0] POS_WEEKDAY = 4'd4;
    localparam logic [3:0] POS_AMPM    = 4'd5;
    localparam logic [3:0] POS_HOUR    = 4'd6;
    localparam logic [3:0] POS_MINUTE  = 4'd7;
    localparam logic [3:0] POS_SECOND  = 4'd8;
    localparam logic [3:0] POS_LAST    = POS_SECOND;

    // clock register addresses
    localparam logic [2:0] ADDR_SECOND  = 3'd0;
    localparam logic [2:0] ADDR_MINUTE  = 3'd1;
    localparam logic [2:0] ADDR_HOUR    = 3'd2;
    localparam logic [2:0] ADDR_WEEKDAY = 3'd3;
    localparam logic [2:0] ADDR_DATE    = 3'd4;
    localparam logic [2:0] ADDR_MONTH   = 3'd5;
    localparam logic [2:0] ADDR_YEAR    = 3'd6;

    // field bounds
    localparam logic [7:0] YEAR_MIN   = 8'h00;
    localparam logic [7:0] YEAR_MAX   = 8'h99;
    localparam logic [7:0] MONTH_MIN  = 8'h01;
    localparam logic [7:0] MONTH_MAX  = 8'h12;
    localparam logic [7:0] DATE_MIN   = 8'h01;
    localparam logic [7:0] DATE_MAX   = 8'h31;
    localparam logic [7:0] MINSEC_MIN = 8'h00;
    localparam logic [7:0] MINSEC_MAX = 8'h59;
    localparam logic [7:0] WDAY_MIN   = 8'h01;
    localparam logic [7:0] WDAY_MAX   = 8'h07;
    localparam logic [4:0] HOUR_MIN   = 5'h01;
    localparam logic [4:0] HOUR_MAX   = 5'h12;
    localparam int         PM_BIT     = 5;

    // divide by ten: multiply by 205 and shift right by 11, exact for 8-bit values
    localparam logic [15:0] DIV10_MUL   = 16'd205;
    localparam int          DIV10_SHIFT = 11;

    // BCD to binary, step by one in 8 bits, back to BCD
    function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic up);
        logic [7:0]  b;
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  qx10;
        logic [7:0]  rem;
        b    = 8'({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
        b    = up ? b + 8'd1 : b - 8'd1;
        prod = {8'd0, b} * DIV10_MUL;
        q    = prod[DIV10_SHIFT +: 5];
        qx10 = 8'({3'd0, q} * 8'd10);
        rem  = b - qx10;
        return {q[3:0], rem[3:0]};
    endfunction

    function automatic logic [7:0] wrap_step(input logic [7:0] v, input logic up,
                                             input logic [7:0] lo, input logic [7:0] hi);
        if (up)
            return (v == hi) ? lo : bcd_step(v, 1'b1);
        return (v == lo) ? hi : bcd_step(v, 1'b0);
    endfunction

endpackage

/* rtl/core/bcd_clock_field_editor_unit.sv */
// channel  | valid        | ready        | payload
// key in   | i_in_valid   | o_in_ready   | i_func, i_year_bcd .. i_second_bcd
// write out| o_out_valid  | i_out_ready  | o_write_valid/addr/data, o_cursor_pos
//
// One beat in, one beat out. A key is taken into the input register, decoded and
// stepped from there and lands in the result register when that register is free;
// one key per cycle is sustained while the write out channel is ready.
// Reset clears the cursor to home and empties both registers.
// While a result waits, one more key is held in the input register.
module bcd_clock_field_editor_unit
    import bcfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_func,
    input  logic [7:0] i_year_bcd,
    input  logic [4:0] i_month_bcd,
    input  logic [5:0] i_date_bcd,
    input  logic [2:0] i_weekday_num,
    input  logic [6:0] i_hour_reg,
    input  logic [6:0] i_minute_bcd,
    input  logic [6:0] i_second_bcd,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_write_valid,
    output logic [2:0] o_write_addr,
    output logic [7:0] o_write_data,
    output logic [3:0] o_cursor_pos
);

    logic       r_s1_valid;
    logic [2:0] r_func;
    logic [7:0] r_year;
    logic [4:0] r_month;
    logic [5:0] r_date;
    logic [2:0] r_wday;
    logic [6:0] r_hour;
    logic [6:0] r_minute;
    logic [6:0] r_second;

    logic [3:0] r_cursor;
    logic [3:0] n_cursor;

    logic       r_out_valid;
    logic       r_wr_valid;
    logic [2:0] r_wr_addr;
    logic [7:0] r_wr_data;
    logic [3:0] r_cursor_pos;
    logic       n_wr_valid;
    logic [2:0] n_wr_addr;
    logic [7:0] n_wr_data;

    logic       out_free;
    logic       s1_adv;
    logic       up;
    logic [7:0] hour8;
    logic [7:0] wday8;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || s1_adv;

    assign up    = (r_func == FUNC_INC);
    assign hour8 = {1'b0, r_hour};
    assign wday8 = {5'd0, r_wday};

    always_comb begin
        n_cursor   = r_cursor;
        n_wr_valid = 1'b0;
        n_wr_addr  = ADDR_SECOND;
        n_wr_data  = 8'h00;
        case (r_func) inside
            FUNC_LEFT: begin
                if (r_cursor <= POS_LAST)
                    n_cursor = (r_cursor == POS_HOME) ? POS_LAST : r_cursor - 4'd1;
            end
            FUNC_RIGHT: begin
                if (r_cursor <= POS_LAST)
                    n_cursor = (r_cursor == POS_LAST) ? POS_HOME : r_cursor + 4'd1;
            end
            FUNC_INC, FUNC_DEC: begin
                n_wr_valid = 1'b1;
                unique case (r_cursor)
                    POS_YEAR: begin
                        n_wr_addr = ADDR_YEAR;
                        n_wr_data = wrap_step(r_year, up, YEAR_MIN, YEAR_MAX);
                    end
                    POS_MONTH: begin
                        n_wr_addr = ADDR_MONTH;
                        n_wr_data = wrap_step({3'd0, r_month}, up, MONTH_MIN, MONTH_MAX);
                    end
                    POS_DATE: begin
                        n_wr_addr = ADDR_DATE;
                        n_wr_data = wrap_step({2'd0, r_date}, up, DATE_MIN, DATE_MAX);
                    end
                    POS_WEEKDAY: begin
                        n_wr_addr = ADDR_WEEKDAY;
                        if (up)
                            n_wr_data = (wday8 == WDAY_MAX) ? WDAY_MIN : wday8 + 8'd1;
                        else
                            n_wr_data = (wday8 == WDAY_MIN) ? WDAY_MAX : wday8 - 8'd1;
                    end
                    POS_AMPM: begin
                        n_wr_addr = ADDR_HOUR;
                        n_wr_data = hour8;
                        n_wr_data[PM_BIT] = !hour8[PM_BIT];
                    end
                    POS_HOUR: begin
                        // wrap on the hour digits only, keep mode bits
                        n_wr_addr = ADDR_HOUR;
                        if (up)
                            n_wr_data = (hour8[4:0] == HOUR_MAX) ? {hour8[7:5], HOUR_MIN}
                                                                 : bcd_step(hour8, 1'b1);
                        else
                            n_wr_data = (hour8[4:0] == HOUR_MIN) ? {hour8[7:5], HOUR_MAX}
                                                                 : bcd_step(hour8, 1'b0);
                    end
                    POS_MINUTE: begin
                        n_wr_addr = ADDR_MINUTE;
                        n_wr_data = wrap_step({1'b0, r_minute}, up, MINSEC_MIN, MINSEC_MAX);
                    end
                    POS_SECOND: begin
                        n_wr_addr = ADDR_SECOND;
                        n_wr_data = wrap_step({1'b0, r_second}, up, MINSEC_MIN, MINSEC_MAX);
                    end
                    default: begin
                        // home writes nothing
                        n_wr_valid = 1'b0;
                    end
                endcase
            end
            default: begin
                n_cursor = r_cursor;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cursor    <= POS_HOME;
        end else begin
            if (o_in_ready)
                r_s1_valid <= i_in_valid;
            if (out_free)
                r_out_valid <= r_s1_valid;
            if (s1_adv)
                r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func   <= i_func;
            r_year   <= i_year_bcd;
            r_month  <= i_month_bcd;
            r_date   <= i_date_bcd;
            r_wday   <= i_weekday_num;
            r_hour   <= i_hour_reg;
            r_minute <= i_minute_bcd;
            r_second <= i_second_bcd;
        end
        if (s1_adv) begin
            r_wr_valid   <= n_wr_valid;
            r_wr_addr    <= n_wr_addr;
            r_wr_data    <= n_wr_data;
            r_cursor_pos <= n_cursor;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_write_valid = r_wr_valid;
    assign o_write_addr  = r_wr_addr;
    assign o_write_data  = r_wr_data;
    assign o_cursor_pos  = r_cursor_pos;

`ifndef NO_ASSERTIONS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= POS_LAST)
        else $error("cursor left the ring");

    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_valid |-> o_write_addr == ADDR_SECOND && o_write_data == 8'h00)
        else $error("no-write result carries address or data");

    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(r_cursor))
        else $error("cursor moved while result stalled");

    a_write_not_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_valid |-> o_cursor_pos != POS_HOME && o_cursor_pos <= POS_LAST)
        else $error("write issued with cursor at home");
`endif

endmodule
